@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, clocked and reset-qualified; compiled out for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ECF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// condition must never be true outside reset
`define ECF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ECF_ASSERT(lbl, clk, rst_n, prop)
`define ECF_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/ecf_pkg.sv @@
// ----------------------------------------------------------------------------
// ecf_pkg
// Shared codes, types and helpers of the command packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package ecf_pkg;

	// input operation codes
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_PAYLOAD = 2'd1;
	localparam logic [1:0] OP_RESP    = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_REQ_BYTE = 2'd0;
	localparam logic [1:0] KIND_RSP_BYTE = 2'd1;
	localparam logic [1:0] KIND_STATUS   = 2'd2;

	// final status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EC_ERR  = 2'd1;
	localparam logic [1:0] ST_BAD_SUM = 2'd2;

	localparam logic [7:0] VERSION_BASE_RST = 8'd220;
	localparam logic [7:0] MAX_LEN          = 8'd255;
	// result code + length byte + checksum
	localparam logic [8:0] HDR_BYTES        = 9'd3;

	// one classified input item: up to four results to emit
	typedef struct packed {
		logic [1:0]      cnt_m1;
		logic [1:0]      kind;
		logic [1:0]      status;
		logic [3:0][7:0] bytes;
	} ecf_job_t;

	function automatic logic [7:0] clamp_len(input logic [7:0] v);
		return (v > MAX_LEN) ? MAX_LEN : v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/ecf_if.sv @@
// ----------------------------------------------------------------------------
// ecf_in_if / ecf_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] cmd_version;
	logic [7:0] command_code;
	logic [7:0] request_length;
	logic [7:0] response_length;
	logic [7:0] data_byte;

	modport source (
		output valid, operation, cmd_version, command_code,
		       request_length, response_length, data_byte,
		input  ready
	);
	modport sink (
		input  valid, operation, cmd_version, command_code,
		       request_length, response_length, data_byte,
		output ready
	);
endinterface

interface ecf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] item_kind;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       is_last;

	modport source (
		output valid, item_kind, out_byte, status, is_last,
		input  ready
	);
	modport sink (
		input  valid, item_kind, out_byte, status, is_last,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/ecf_front.sv @@
// ----------------------------------------------------------------------------
// ecf_front
// Accepts input items, tracks framing/deframing state and turns each item that
// yields output into a job of one to four results for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ecf_front import ecf_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	ecf_in_if.sink      item_in,
	input  wire logic   q_full,
	output logic        q_push,
	output ecf_job_t    q_job
);

	logic [7:0] version_base_q;
	logic [7:0] request_sum_q;
	logic [7:0] request_left_q;
	logic [7:0] response_sum_q;
	logic [7:0] response_len_q;
	logic [8:0] response_pos_q;
	logic       ec_error_q;
	logic       response_active_q;

	logic       accept;
	logic [7:0] hdr;
	logic [7:0] req_len;
	logic [7:0] pay_sum;
	logic [8:0] rsp_end;
	logic       rsp_take;
	logic       rsp_final;

	assign item_in.ready = !q_full;
	assign accept        = item_in.valid && item_in.ready;

	// shared arithmetic
	assign hdr       = version_base_q + item_in.cmd_version;
	assign req_len   = clamp_len(item_in.request_length);
	assign pay_sum   = request_sum_q + item_in.data_byte;
	assign rsp_end   = HDR_BYTES - 9'd1 + {1'b0, response_len_q};
	assign rsp_take  = response_active_q && (request_left_q == 8'd0);
	assign rsp_final = response_pos_q >= rsp_end;

	// classify the item into a job
	always_comb begin
		q_job  = '0;
		q_push = 1'b0;
		case (item_in.operation)
			OP_START: begin
				q_job.kind     = KIND_REQ_BYTE;
				q_job.bytes[0] = hdr;
				q_job.bytes[1] = item_in.command_code;
				q_job.bytes[2] = req_len;
				q_job.bytes[3] = hdr + item_in.command_code + req_len;
				q_job.cnt_m1   = (req_len == 8'd0) ? 2'd3 : 2'd2;
				q_push         = accept;
			end
			OP_PAYLOAD: begin
				q_job.kind     = KIND_REQ_BYTE;
				q_job.bytes[0] = item_in.data_byte;
				q_job.bytes[1] = pay_sum;
				q_job.cnt_m1   = (request_left_q == 8'd1) ? 2'd1 : 2'd0;
				q_push         = accept && (request_left_q != 8'd0);
			end
			OP_RESP: begin
				if (rsp_final) begin
					q_job.kind = KIND_STATUS;
					if (ec_error_q)
						q_job.status = ST_EC_ERR;
					else if (response_sum_q != item_in.data_byte)
						q_job.status = ST_BAD_SUM;
					else
						q_job.status = ST_OK;
					q_push = accept && rsp_take;
				end else begin
					q_job.kind     = KIND_RSP_BYTE;
					q_job.bytes[0] = item_in.data_byte;
					q_push         = accept && rsp_take && (response_pos_q >= 9'd2)
					                 && !ec_error_q;
				end
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_base_q <= VERSION_BASE_RST;
		end else if (cfg_wr_en) begin
			version_base_q <= cfg_wr_data;
		end
	end

	// exchange state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_sum_q     <= '0;
			request_left_q    <= '0;
			response_sum_q    <= '0;
			response_len_q    <= '0;
			response_pos_q    <= '0;
			ec_error_q        <= 1'b0;
			response_active_q <= 1'b0;
		end else if (accept) begin
			case (item_in.operation)
				OP_START: begin
					request_sum_q     <= hdr + item_in.command_code + req_len;
					request_left_q    <= req_len;
					response_len_q    <= clamp_len(item_in.response_length);
					response_sum_q    <= '0;
					response_pos_q    <= '0;
					ec_error_q        <= 1'b0;
					response_active_q <= 1'b1;
				end
				OP_PAYLOAD: begin
					if (request_left_q != 8'd0) begin
						request_sum_q  <= pay_sum;
						request_left_q <= request_left_q - 8'd1;
					end
				end
				OP_RESP: begin
					if (rsp_take) begin
						if (rsp_final) begin
							response_active_q <= 1'b0;
							response_pos_q    <= '0;
						end else begin
							if ((response_pos_q == 9'd0) && (item_in.data_byte != 8'd0))
								ec_error_q <= 1'b1;
							response_sum_q <= response_sum_q + item_in.data_byte;
							response_pos_q <= response_pos_q + 9'd1;
						end
					end
				end
				default: begin
					response_active_q <= response_active_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/ecf_queue.sv @@
// ----------------------------------------------------------------------------
// ecf_queue
// Small job FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ecf_queue import ecf_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire ecf_job_t push_job,
	output logic          full,
	input  wire logic     pop,
	output logic          not_empty,
	output ecf_job_t      head_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ecf_job_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	`ECF_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH))
	`ECF_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !not_empty)

endmodule

`default_nettype wire

@@ rtl/ecf_back.sv @@
// ----------------------------------------------------------------------------
// ecf_back
// Takes jobs from the queue and emits their results one per cycle, while a job
// is loaded and the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ecf_back import ecf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_not_empty,
	input  wire ecf_job_t q_head,
	output logic          q_pop,
	ecf_out_if.source     item_out
);

	ecf_job_t   job_q;
	logic       job_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_status_q;
	logic       out_last_q;

	logic emit;
	logic last;

	assign emit  = job_valid_q && (!out_valid_q || item_out.ready);
	assign last  = (idx_q == job_q.cnt_m1);
	assign q_pop = q_not_empty && (!job_valid_q || (emit && last));

	// current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (q_pop) begin
			job_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (emit) begin
			if (last)
				job_valid_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (item_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q   <= job_q.kind;
			out_byte_q   <= job_q.bytes[idx_q];
			out_status_q <= job_q.status;
			out_last_q   <= last;
		end
	end

	assign item_out.valid     = out_valid_q;
	assign item_out.item_kind = out_kind_q;
	assign item_out.out_byte  = out_byte_q;
	assign item_out.status    = out_status_q;
	assign item_out.is_last   = out_last_q;

	`ECF_ASSERT(a_idx_range, clk, arst_n, job_valid_q |-> (idx_q <= job_q.cnt_m1))
	`ECF_ASSERT(a_job_done, clk, arst_n, (emit && last && !q_pop) |=> !job_valid_q)

endmodule

`default_nettype wire

@@ rtl/ec_command_packet_framer_top.sv @@
// An item's first result passes the job queue, job register and output register.
// The back end emits one result per cycle while the output is not stalled; a start
// item yields 3 or 4 results, a payload item 1 or 2, a response byte at most 1.
// Input items are taken one per cycle while the job queue (QUEUE_DEPTH) has room.
// Reset (arst_n, async, active low): idle, sums/counters cleared, version_base = 220.
// ----------------------------------------------------------------------------
// ec_command_packet_framer_top
// Embedded controller command framer and response deframer, one byte a step.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_command_packet_framer_top import ecf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	ecf_in_if.sink      item_in,
	ecf_out_if.source   item_out
);

	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_not_empty;
	ecf_job_t q_in_job;
	ecf_job_t q_head;

	// classify and track state
	ecf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_in     (item_in),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_in_job)
	);

	// decoupling queue
	ecf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_in_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_job  (q_head)
	);

	// emit results
	ecf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.item_out    (item_out)
	);

endmodule

`default_nettype wire
